// ===== src/otsu_threshold_trimmed_top_assert.svh =====
// Assertion macros used by the top RTL file of the trimmed Otsu threshold block.
`ifndef OTSU_THRESHOLD_TRIMMED_TOP_ASSERT_SVH
`define OTSU_THRESHOLD_TRIMMED_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OTT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define OTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/otsu_trim_pkg.sv =====
`default_nettype none
package otsu_trim_pkg;

  // Kind of threshold decision carried in the result tuser.
  typedef enum logic [1:0] {
    LC_OTSU   = 2'd0,
    LC_SINGLE = 2'd1,
    LC_PAIR   = 2'd2
  } level_case_t;

  // Configuration register indexes.
  localparam logic [7:0] CFG_LOW_TRIM  = 8'd0;
  localparam logic [7:0] CFG_HIGH_TRIM = 8'd1;

  // Register reset values.
  localparam logic [15:0] LOW_TRIM_RESET  = 16'd5;
  localparam logic [15:0] HIGH_TRIM_RESET = 16'd15;

  // Frame sequencer states.
  typedef enum logic [4:0] {
    S_ACCEPT,
    S_DRAIN,
    S_LO_RD,
    S_LO_CHK,
    S_HI_RD,
    S_HI_CHK,
    S_DECIDE,
    S_TOT_RD,
    S_TOT_ACC,
    S_SRCH_RD,
    S_SRCH_ACC,
    S_MUL_X,
    S_MUL_Y,
    S_MUL_P,
    S_MUL_SQ,
    S_MUL_L,
    S_MUL_R,
    S_CMP,
    S_OUT,
    S_CLEAR
  } seq_state_t;

  // Control of the histogram memory from the sequencer.
  typedef struct packed {
    logic pix_valid;
    logic rd_en;
    logic clr_en;
  } hist_ctrl_t;

  // Status of the shift-add multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage
`default_nettype wire

// ===== src/otsu_threshold_trimmed_top.sv =====
// Otsu threshold of 8-bit gray frames. Pixels enter at one per clock and are
// counted in a GRAY_LEVELS-bin histogram memory (read, increment, write back
// with forwarding). The pixel with tlast closes the frame; input is then held
// off while a sequencer trims sparse end bins and searches the kept range one
// level at a time (or reports one or two kept levels directly), running the
// products of each level on a shared shift-add multiplier (four on the first
// level, six after). After the result is placed in the output register, a
// clearing pass empties the histogram; the same pass runs after reset before
// the first pixel is taken.
// Configuration writes are taken at any time and should be made between frames.
`default_nettype none
module otsu_threshold_trimmed_top
  import otsu_trim_pkg::*;
#(
  parameter int GRAY_LEVELS = 256,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Pixel stream. tdata: pixel[7:0].
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        s_axis_tlast,
  // Result stream. tdata: threshold[7:0]. tuser: level_case[1:0].
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,
  output logic [1:0]       m_axis_tuser,
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  `include "otsu_threshold_trimmed_top_assert.svh"

  localparam int LB   = $clog2(GRAY_LEVELS);
  localparam int CB   = COUNT_BITS;
  localparam int NW   = CB + LB;
  localparam int SW   = CB + 2 * LB;
  localparam int DW   = SW + NW;
  localparam int PW   = 2 * NW;
  localparam int SQW  = 2 * DW;
  localparam int CW   = SQW + PW;
  localparam int MAW  = SQW;
  localparam int MBW  = DW;
  localparam logic [LB-1:0] TOP = LB'(GRAY_LEVELS - 1);
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};

  // Saturating add of two bin counts.
  function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] x, input logic [CB-1:0] y);
    logic [CB:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[CB] ? CMAX : s[CB-1:0];
  endfunction

  seq_state_t state, state_next;

  logic [15:0]   low_trim;
  logic [15:0]   high_trim;
  logic [LB-1:0] lo, hi, j, best, best_level;
  logic [CB-1:0] low_sum, high_sum;
  logic [NW-1:0] n_tot, nb;
  logic [SW-1:0] s_tot, sb;
  logic [DW-1:0] x, y, d;
  logic [PW-1:0] p, bp;
  logic [SQW-1:0] sq, bsq;
  logic [CW-1:0] lhs, rhs;
  logic          have;
  logic          mul_issued;
  logic [7:0]    res_thr;
  level_case_t   res_kind;
  level_case_t   out_kind;

  hist_ctrl_t    hctrl;
  logic [LB-1:0] pix_addr;
  logic [LB-1:0] rd_addr;
  logic [CB-1:0] rd_data;
  logic [CB-1:0] eff;
  logic [CB+LB-1:0] eff_w;

  logic            mul_start;
  logic [MAW-1:0]  mul_a;
  logic [MBW-1:0]  mul_b;
  mul_stat_t       mul_stat;
  logic [MAW+MBW-1:0] mul_prod;

  logic pix_acc;
  logic out_free;

  assign cfg_ready    = 1'b1;
  assign pix_acc      = s_axis_tvalid && s_axis_tready;
  assign out_free     = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tuser = out_kind;

  // Pixels beyond the level range count in the top bin.
  assign pix_addr = (s_axis_tdata > 8'(GRAY_LEVELS - 1)) ? TOP : s_axis_tdata[LB-1:0];

  // Bin value after folding the trimmed ends into the kept end bins.
  always_comb begin
    eff = rd_data;
    if (j == hi) begin
      eff = sat_add(eff, high_sum);
    end
    if (j == lo) begin
      eff = sat_add(eff, low_sum);
    end
    eff_w = {{LB{1'b0}}, eff} * {{CB{1'b0}}, j};
  end

  otsu_trim_hist #(
    .LB (LB),
    .CB (CB)
  ) u_hist (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (hctrl),
    .pix_addr (pix_addr),
    .rd_addr  (rd_addr),
    .clr_addr (j),
    .rd_data  (rd_data)
  );

  otsu_trim_mul #(
    .AW (MAW),
    .BW (MBW)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .prod  (mul_prod)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_ACCEPT:   if (pix_acc && s_axis_tlast) state_next = S_DRAIN;
      S_DRAIN:    state_next = S_LO_RD;
      S_LO_RD:    state_next = S_LO_CHK;
      S_LO_CHK: begin
        if (rd_data > low_trim) begin
          state_next = S_HI_RD;
        end else if (j == TOP) begin
          state_next = S_OUT;
        end else begin
          state_next = S_LO_RD;
        end
      end
      S_HI_RD:    state_next = (hi == lo) ? S_DECIDE : S_HI_CHK;
      S_HI_CHK:   state_next = (rd_data > high_trim) ? S_DECIDE : S_HI_RD;
      S_DECIDE:   state_next = (hi == lo || lo + 1'b1 == hi) ? S_OUT : S_TOT_RD;
      S_TOT_RD:   state_next = S_TOT_ACC;
      S_TOT_ACC:  state_next = (j == hi) ? S_SRCH_RD : S_TOT_RD;
      S_SRCH_RD:  state_next = S_SRCH_ACC;
      S_SRCH_ACC: state_next = S_MUL_X;
      S_MUL_X:    if (mul_stat.done) state_next = S_MUL_Y;
      S_MUL_Y:    if (mul_stat.done) state_next = S_MUL_P;
      S_MUL_P:    if (mul_stat.done) state_next = S_MUL_SQ;
      S_MUL_SQ:   if (mul_stat.done) state_next = have ? S_MUL_L : S_CMP;
      S_MUL_L:    if (mul_stat.done) state_next = S_MUL_R;
      S_MUL_R:    if (mul_stat.done) state_next = S_CMP;
      S_CMP:      state_next = (j + 1'b1 == hi) ? S_OUT : S_SRCH_RD;
      S_OUT:      if (out_free) state_next = S_CLEAR;
      S_CLEAR:    if (j == TOP) state_next = S_ACCEPT;
      default:    state_next = S_CLEAR;
    endcase
  end

  // State outputs: memory control and multiplier operands.
  always_comb begin
    hctrl         = '0;
    rd_addr       = j;
    s_axis_tready = 1'b0;
    mul_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state)
      S_ACCEPT: begin
        s_axis_tready   = 1'b1;
        hctrl.pix_valid = pix_acc;
      end
      S_LO_RD, S_TOT_RD, S_SRCH_RD: hctrl.rd_en = 1'b1;
      S_HI_RD: begin
        hctrl.rd_en = 1'b1;
        rd_addr     = hi;
      end
      S_MUL_X: begin
        mul_start = !mul_issued;
        mul_a     = MAW'(sb);
        mul_b     = MBW'(n_tot);
      end
      S_MUL_Y: begin
        mul_start = !mul_issued;
        mul_a     = MAW'(s_tot);
        mul_b     = MBW'(nb);
      end
      S_MUL_P: begin
        mul_start = !mul_issued;
        mul_a     = MAW'(nb);
        mul_b     = MBW'(n_tot - nb);
      end
      S_MUL_SQ: begin
        mul_start = !mul_issued;
        mul_a     = MAW'(d);
        mul_b     = MBW'(d);
      end
      S_MUL_L: begin
        mul_start = !mul_issued;
        mul_a     = MAW'(sq);
        mul_b     = MBW'(bp);
      end
      S_MUL_R: begin
        mul_start = !mul_issued;
        mul_a     = MAW'(bsq);
        mul_b     = MBW'(p);
      end
      S_CLEAR: hctrl.clr_en = 1'b1;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      j             <= '0;
      low_trim      <= LOW_TRIM_RESET;
      high_trim     <= HIGH_TRIM_RESET;
      best_level    <= '0;
      mul_issued    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;

      // Register writes; unknown indexes are ignored.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_LOW_TRIM) begin
          low_trim <= cfg_data;
        end else if (cfg_index == CFG_HIGH_TRIM) begin
          high_trim <= cfg_data;
        end
      end

      if (mul_start) begin
        mul_issued <= 1'b1;
      end else if (mul_stat.done) begin
        mul_issued <= 1'b0;
      end

      // A new result replaces the one that leaves in the same cycle.
      if (state == S_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_DRAIN:  j <= '0;
        S_LO_CHK: if (rd_data <= low_trim && j != TOP) j <= j + 1'b1;
        S_DECIDE: j <= lo;
        S_TOT_ACC: j <= (j == hi) ? lo : j + 1'b1;
        S_CMP: begin
          j <= j + 1'b1;
          if (j + 1'b1 == hi) begin
            best_level <= (!have || lhs > rhs) ? j : best;
          end
        end
        S_OUT:   j <= '0;
        S_CLEAR: j <= j + 1'b1;
        default: ;
      endcase
    end
  end

  // Frame datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_DRAIN: begin
        low_sum  <= '0;
        high_sum <= '0;
        hi       <= TOP;
        res_thr  <= 8'(best_level);
        res_kind <= LC_OTSU;
      end
      S_LO_CHK: begin
        if (rd_data <= low_trim) begin
          low_sum <= sat_add(low_sum, rd_data);
        end else begin
          lo <= j;
        end
      end
      S_HI_CHK: begin
        if (rd_data <= high_trim) begin
          high_sum <= sat_add(high_sum, rd_data);
          hi       <= hi - 1'b1;
        end
      end
      S_DECIDE: begin
        n_tot   <= '0;
        s_tot   <= '0;
        nb      <= '0;
        sb      <= '0;
        have    <= 1'b0;
        res_thr <= 8'(lo);
        res_kind <= (hi == lo) ? LC_SINGLE : LC_PAIR;
      end
      S_TOT_ACC: begin
        n_tot <= n_tot + NW'(eff);
        s_tot <= s_tot + SW'(eff_w);
      end
      S_SRCH_ACC: begin
        nb <= nb + NW'(eff);
        sb <= sb + SW'(eff_w);
      end
      S_MUL_X: if (mul_stat.done) x <= DW'(mul_prod);
      S_MUL_Y: if (mul_stat.done) y <= DW'(mul_prod);
      S_MUL_P: begin
        if (mul_stat.done) begin
          p <= PW'(mul_prod);
          d <= (x >= y) ? x - y : y - x;
        end
      end
      S_MUL_SQ: if (mul_stat.done) sq <= SQW'(mul_prod);
      S_MUL_L:  if (mul_stat.done) lhs <= CW'(mul_prod);
      S_MUL_R:  if (mul_stat.done) rhs <= CW'(mul_prod);
      S_CMP: begin
        // A later level wins only with a strictly larger variance.
        if (!have || lhs > rhs) begin
          have <= 1'b1;
          best <= j;
          bsq  <= sq;
          bp   <= p;
          if (j + 1'b1 == hi) begin
            res_thr  <= 8'(j);
            res_kind <= LC_OTSU;
          end
        end else if (j + 1'b1 == hi) begin
          res_thr  <= 8'(best);
          res_kind <= LC_OTSU;
        end
      end
      S_OUT: begin
        if (out_free) begin
          m_axis_tdata <= res_thr;
          out_kind     <= res_kind;
        end
      end
      default: ;
    endcase
  end

  // The multiplier only reports a product that the sequencer asked for.
  `OTT_ASSERT_NOW(a_mul_done_issued, clk, rst, mul_stat.done, mul_issued)
  // The search never steps onto the highest kept level.
  `OTT_ASSERT_NOW(a_search_range, clk, rst, state == S_CMP, j < hi && j >= lo)
  // A new result appears only from the output step.
  `OTT_ASSERT_NEXT(a_result_source, clk, rst, !m_axis_tvalid && state != S_OUT, !m_axis_tvalid)
  // Pixels are taken only while the multiplier is idle and no product is outstanding.
  `OTT_ASSERT_NOW(a_no_pixel_busy, clk, rst, s_axis_tready, !mul_stat.busy && !mul_issued)

endmodule
`default_nettype wire

// ===== src/otsu_trim_hist.sv =====
`default_nettype none
module otsu_trim_hist
  import otsu_trim_pkg::*;
#(
  parameter int LB = 8,
  parameter int CB = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire hist_ctrl_t    ctrl,
  input  wire logic [LB-1:0] pix_addr,
  input  wire logic [LB-1:0] rd_addr,
  input  wire logic [LB-1:0] clr_addr,
  output logic      [CB-1:0] rd_data
);

  localparam int DEPTH = 1 << LB;
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};

  logic [CB-1:0] mem [DEPTH];

  logic          s1_valid;
  logic [LB-1:0] s1_addr;
  logic          wr_valid;
  logic [LB-1:0] wr_addr;
  logic [CB-1:0] wr_data;

  logic [LB-1:0] raddr;
  logic [CB-1:0] cur;
  logic [CB-1:0] upd;
  logic          we;
  logic [LB-1:0] waddr;
  logic [CB-1:0] wdata;

  // A pixel reads its bin at acceptance and writes it back in the following cycle.
  assign raddr = ctrl.pix_valid ? pix_addr : rd_addr;

  // Forward the bin written on the previous cycle, which the read missed.
  assign cur = (wr_valid && wr_addr == s1_addr) ? wr_data : rd_data;
  assign upd = (cur == CMAX) ? CMAX : cur + 1'b1;

  assign we    = s1_valid || ctrl.clr_en;
  assign waddr = s1_valid ? s1_addr : clr_addr;
  assign wdata = s1_valid ? upd : '0;

  // Memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctrl.pix_valid || ctrl.rd_en) begin
      rd_data <= mem[raddr];
    end
  end

  // Increment pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_valid <= 1'b0;
    end else begin
      s1_valid <= ctrl.pix_valid;
      wr_valid <= s1_valid;
    end
  end

  // Increment pipeline payload.
  always_ff @(posedge clk) begin
    s1_addr <= pix_addr;
    wr_addr <= s1_addr;
    wr_data <= upd;
  end

endmodule
`default_nettype wire

// ===== src/otsu_trim_mul.sv =====
`default_nettype none
module otsu_trim_mul
  import otsu_trim_pkg::*;
#(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output mul_stat_t             stat,
  output logic      [AW+BW-1:0] prod
);

  logic [AW+BW-1:0] a_sh;
  logic [BW-1:0]    b_sh;
  logic             busy;
  logic             done;

  assign stat.busy = busy;
  assign stat.done = done;

  // Control: run until no multiplier bits remain, then pulse done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (busy && b_sh == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Shift-add datapath, one multiplier bit per cycle.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      a_sh <= {{BW{1'b0}}, a};
      b_sh <= b;
      prod <= '0;
    end else if (busy && b_sh != '0) begin
      if (b_sh[0]) begin
        prod <= prod + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_otsu_threshold_trimmed_top.sv =====
`default_nettype none
module tb_otsu_threshold_trimmed_top;
  import otsu_trim_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS = 256;
  localparam int CYCLE_LIMIT = 20000000;
  // Pause after the last result so the clearing pass can finish.
  localparam int SETTLE_CYCLES = 600;
  // An index past the last register; writes to it are dropped.
  localparam logic [7:0] CFG_UNUSED = 8'd2;

  typedef struct packed {
    logic [7:0]  thr;
    level_case_t lc;
  } frame_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [15:0] cfg_data;

  otsu_threshold_trimmed_top dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Predictor state: histogram, trim registers and the held Otsu level.
  logic [15:0]   bin_count [LEVELS];
  logic [15:0]   low_trim_q;
  logic [15:0]   high_trim_q;
  logic [7:0]    held_level;
  frame_result_t pending_thresholds[$];

  int  error_count;
  int  pixel_count;
  int  frame_count;
  int  otsu_count;
  int  single_count;
  int  pair_count;
  int  cycle_count;
  bit  calm;
  int  stall_left;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // Exact Otsu search over the kept range [lo, hi); first maximum wins.
  function automatic logic [7:0] otsu_level(input int lo, input int hi);
    longint unsigned n_all, s_all, n_back, s_back, x, y, d, p;
    logic [255:0] sq, best_sq, best_p, lhs, rhs;
    bit have;
    int best;
    n_all = 0;
    s_all = 0;
    n_back = 0;
    s_back = 0;
    best_sq = '0;
    best_p = '0;
    have = 1'b0;
    best = lo;
    for (int j = lo; j <= hi; j++) begin
      n_all += bin_count[j];
      s_all += longint'(bin_count[j]) * j;
    end
    for (int j = lo; j < hi; j++) begin
      n_back += bin_count[j];
      s_back += longint'(bin_count[j]) * j;
      x = s_back * n_all;
      y = s_all * n_back;
      d = (x >= y) ? x - y : y - x;
      p = n_back * (n_all - n_back);
      sq = 256'(d);
      sq = sq * sq;
      if (have) begin
        lhs = sq * best_p;
        rhs = best_sq * 256'(p);
        if (lhs <= rhs) continue;
      end
      have = 1'b1;
      best = j;
      best_sq = sq;
      best_p = 256'(p);
    end
    return best[7:0];
  endfunction

  // Count one accepted pixel; on the last pixel work out the frame's threshold.
  task automatic count_pixel(input logic [7:0] px, input logic last);
    int lo, hi;
    logic [15:0] low_sum, high_sum;
    frame_result_t r;
    bin_count[px] = sat_add(bin_count[px], 16'd1);
    pixel_count++;
    if (last) begin
      low_sum = '0;
      high_sum = '0;
      lo = 0;
      while (lo < LEVELS && bin_count[lo] <= low_trim_q) begin
        low_sum = sat_add(low_sum, bin_count[lo]);
        bin_count[lo] = '0;
        lo++;
      end
      if (lo >= LEVELS) begin
        r.thr = held_level;
        r.lc = LC_OTSU;
      end else begin
        hi = LEVELS - 1;
        while (hi > lo && bin_count[hi] <= high_trim_q) begin
          high_sum = sat_add(high_sum, bin_count[hi]);
          bin_count[hi] = '0;
          hi--;
        end
        bin_count[hi] = sat_add(bin_count[hi], high_sum);
        bin_count[lo] = sat_add(bin_count[lo], low_sum);
        if (hi == lo) begin
          r.thr = hi[7:0];
          r.lc = LC_SINGLE;
          single_count++;
        end else if (lo + 1 == hi) begin
          r.thr = lo[7:0];
          r.lc = LC_PAIR;
          pair_count++;
        end else begin
          r.thr = otsu_level(lo, hi);
          held_level = r.thr;
          r.lc = LC_OTSU;
          otsu_count++;
        end
      end
      foreach (bin_count[i]) bin_count[i] = '0;
      pending_thresholds.push_back(r);
      frame_count++;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (calm || roll < 12) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one pixel transfer; called right after a rising edge.
  task automatic send_pixel(input logic [7:0] px, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    count_pixel(px, last);
  endtask

  // Write one register once the block has delivered everything and settled.
  task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_thresholds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_LOW_TRIM) low_trim_q = value;
    else if (idx == CFG_HIGH_TRIM) high_trim_q = value;
  endtask

  task automatic set_trims(input logic [15:0] lo_t, input logic [15:0] hi_t);
    write_reg(CFG_LOW_TRIM, lo_t);
    write_reg(CFG_HIGH_TRIM, hi_t);
  endtask

  task automatic send_frame(input logic [7:0] pixels[$]);
    foreach (pixels[i]) send_pixel(pixels[i], i == pixels.size() - 1);
  endtask

  // Fixed frames: trimmed away, single level, adjacent pair and Otsu splits.
  task automatic test_directed();
    send_frame('{8'd0});
    set_trims(16'd0, 16'd0);
    send_frame('{8'd255});
    send_frame('{8'd7, 8'd8});
    send_frame('{8'd0, 8'd0, 8'd128, 8'd255, 8'd255});
    send_frame('{8'h55, 8'hAA, 8'h0F, 8'hF0});
    send_frame('{8'd3, 8'd3, 8'd4, 8'd200, 8'd201, 8'd201});
  endtask

  // Register extremes and a write to an index that is not a register.
  task automatic test_register_extremes();
    set_trims(16'hFFFF, 16'hFFFF);
    send_frame('{8'd10, 8'd20, 8'd30});
    set_trims(16'd0, 16'hFFFF);
    send_frame('{8'd40, 8'd50, 8'd60});
    write_reg(CFG_UNUSED, 16'(($urandom())));
    send_frame('{8'd1, 8'd1, 8'd2, 8'd9});
    set_trims(16'd1, 16'd0);
    send_frame('{8'd90, 8'd90, 8'd95, 8'd99, 8'd99, 8'd99});
  endtask

  // Random frames, mostly on a narrow band of levels, with changing trims.
  task automatic test_random_frames();
    logic [7:0] frame[$];
    int len, base, width, start_frames;
    start_frames = frame_count;
    while (pixel_count < 750 || frame_count - start_frames < 40) begin
      if ((frame_count - start_frames) % 8 == 0) begin
        set_trims(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)));
        calm = ($urandom_range(0, 3) == 0);
      end
      frame.delete();
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(10, 30);
        repeat (len) frame.push_back(8'($urandom()));
      end else begin
        len = $urandom_range(1, 25);
        width = $urandom_range(1, 16);
        base = $urandom_range(0, LEVELS - width);
        repeat (len) frame.push_back(8'(base + $urandom_range(0, width - 1)));
      end
      send_frame(frame);
    end
  endtask

  // Result side back-pressure: mostly ready, short stalls, a few long ones.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (calm || $urandom_range(0, 9) < 7) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 2);
    end
  end

  // Compare each result transfer with the oldest expected threshold.
  always @(posedge clk) begin
    frame_result_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_thresholds.size() == 0) begin
        report_mismatch($sformatf("unexpected result thr=%0d case=%0d",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        exp_r = pending_thresholds.pop_front();
        if (m_axis_tdata !== exp_r.thr)
          report_mismatch($sformatf("threshold %0d, expected %0d",
                                    m_axis_tdata, exp_r.thr));
        if (m_axis_tuser !== exp_r.lc)
          report_mismatch($sformatf("level case %0d, expected %0d",
                                    m_axis_tuser, exp_r.lc));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tlast <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    error_count = 0;
    pixel_count = 0;
    frame_count = 0;
    otsu_count = 0;
    single_count = 0;
    pair_count = 0;
    calm = 1'b0;
    low_trim_q = LOW_TRIM_RESET;
    high_trim_q = HIGH_TRIM_RESET;
    held_level = '0;
    foreach (bin_count[i]) bin_count[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_register_extremes();
    test_random_frames();

    s_axis_tvalid <= 1'b0;
    while (pending_thresholds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d pixels in %0d frames under several trim settings.",
             pixel_count, frame_count);
    $display("Decisions: %0d Otsu searches, %0d single levels, %0d adjacent pairs.",
             otsu_count, single_count, pair_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
